>>> src/wpls_pkg.sv
// Shared types, codes and constants of the winch position limit supervisor.
// No dependencies; imported by every module of the block.
package wpls_pkg;

	// Field widths
	localparam int unsigned POS_W     = 14;
	localparam int unsigned LIMMAX_W  = 13;
	localparam int unsigned SPEED_W   = 9;
	localparam int unsigned DEB_W     = 10;
	localparam int unsigned CMD_W     = 3;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_W     = 14;

	// Fixed limits
	localparam logic [SPEED_W-1:0]  SPEED_FULL     = SPEED_W'(400);
	localparam logic [POS_W-1:0]    POS_MAX        = {POS_W{1'b1}};
	localparam logic [DEB_W-1:0]    TIMER_MAX      = {DEB_W{1'b1}};
	localparam logic [LIMMAX_W-1:0] POS_LIMIT_MAX  = LIMMAX_W'(4096);

	// Register reset values
	localparam logic [DEB_W-1:0]    TOP_DEB_RESET   = DEB_W'(150);
	localparam logic [DEB_W-1:0]    SLACK_DEB_RESET = DEB_W'(350);
	localparam logic [POS_W-1:0]    MIN_POS_RESET   = POS_W'(1);
	localparam logic [LIMMAX_W-1:0] MAX_POS_RESET   = POS_LIMIT_MAX;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_DEB   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SLACK_DEB = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_POS   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS   = CFG_IDX_W'(3);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_ENCODER = 3'd1,
		CMD_SET_DIR = 3'd2,
		CMD_SET_TGT = 3'd3,
		CMD_SET_POS = 3'd4,
		CMD_SET_SPD = 3'd5,
		CMD_GO_TGT  = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		M_UP        = 3'd0,
		M_DOWN      = 3'd1,
		M_TO_TARGET = 3'd2,
		M_AT_TARGET = 3'd3,
		M_TOP       = 3'd4,
		M_SLACK     = 3'd5,
		M_MIN       = 3'd6,
		M_MAX       = 3'd7
	} mode_t;

	// Debouncer report towards the supervisor logic
	typedef struct packed {
		logic taken;   // a new stable level is taken on this tick
		logic level;   // the level that is taken
	} dbn_status_t;

	// Travel mode that matches a direction
	function automatic mode_t dir_mode(input logic up);
		return up ? M_UP : M_DOWN;
	endfunction

	// Constrain to [min,max]; when min > max, a value below min gets min, any other gets max
	function automatic logic [POS_W-1:0] clamp_pos(
		input logic [POS_W-1:0]    v,
		input logic [POS_W-1:0]    lo,
		input logic [LIMMAX_W-1:0] hi
	);
		logic [POS_W-1:0] hi_ext;
		hi_ext = POS_W'(hi);
		if (v < lo) begin
			return lo;
		end else if (v > hi_ext) begin
			return hi_ext;
		end
		return v;
	endfunction

endpackage

>>> src/wpls_debounce.sv
// Debouncer for one end-stop sensor, stepped once per millisecond tick.
// Depends on wpls_pkg for widths and the status struct.
module wpls_debounce #(
	parameter bit RESET_LEVEL = 1'b0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       raw,
	input  logic [wpls_pkg::DEB_W-1:0] delay,
	output wpls_pkg::dbn_status_t      status
);
	import wpls_pkg::*;

	logic             last_q;
	logic             stable_q;
	logic [DEB_W-1:0] timer_q;
	logic [DEB_W-1:0] timer_d;

	// Restart on a level change, otherwise count up and saturate
	always_comb begin
		if (raw != last_q) begin
			timer_d = '0;
		end else if (timer_q != TIMER_MAX) begin
			timer_d = timer_q + DEB_W'(1);
		end else begin
			timer_d = timer_q;
		end
	end

	assign status.taken = (timer_d > delay) && (raw != stable_q);
	assign status.level = raw;

	// Advance only on an accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= RESET_LEVEL;
			stable_q <= RESET_LEVEL;
			timer_q  <= '0;
		end else if (en) begin
			last_q  <= raw;
			timer_q <= timer_d;
			if (status.taken) begin
				stable_q <= raw;
			end
		end
	end

endmodule

>>> src/winch_position_limit_supervisor.sv
// Winch position limit supervisor: top level with input stage, state and result register.
// Depends on wpls_pkg and wpls_debounce.
//
// Usage:
//   Input words (cmd, top_sensor, slack_sensor, value) enter on in_valid while
//   in_stall is low. Each word produces exactly one result word (mode,
//   mode_changed, drive_speed, moving_up, position) on out_valid, taken when
//   out_stall is low. Configuration registers are written over cfg_valid /
//   cfg_ready with cfg_index and cfg_data; cfg_ready is always high and a write
//   to an index beyond the register list is dropped. Write configuration only
//   while no word is in flight.
//   Path: a word taken into the input register loads the result register as soon
//   as the result register is free or its word is being taken.
//   Throughput: one word per cycle while out_stall is low. The input register feeds
//   one pass of compare and update logic on the supervisor state, which loads the
//   result register; nothing iterates.
//   Stall: while a result waits on out_stall, one more word is taken into the
//   input register; in_stall rises only when both registers are full.
//   Reset: arst_n clears all handshake and supervisor state to its reset
//   values at once; the block is ready as soon as reset is released.
module winch_position_limit_supervisor (
	input  logic                           clk,
	input  logic                           arst_n,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [wpls_pkg::CMD_W-1:0]     cmd,
	input  logic                           top_sensor,
	input  logic                           slack_sensor,
	input  logic [wpls_pkg::POS_W-1:0]     value,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     mode,
	output logic                           mode_changed,
	output logic [wpls_pkg::SPEED_W-1:0]   drive_speed,
	output logic                           moving_up,
	output logic [wpls_pkg::POS_W-1:0]     position,
	// configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wpls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wpls_pkg::CFG_W-1:0]     cfg_data
);
	import wpls_pkg::*;

	// Configuration registers
	logic [DEB_W-1:0]    top_deb_q;
	logic [DEB_W-1:0]    slack_deb_q;
	logic [POS_W-1:0]    min_pos_q;
	logic [LIMMAX_W-1:0] max_pos_q;

	// Input stage
	logic             vld_s1;
	cmd_t             cmd_s1;
	logic             top_s1;
	logic             slack_s1;
	logic [POS_W-1:0] value_s1;

	// Supervisor state
	mode_t            mode_q;
	logic [SPEED_W-1:0] speed_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] tgt_q;
	logic             dir_q;

	// Result register
	logic             out_valid_q;
	mode_t            res_mode_q;
	logic             res_changed_q;
	logic [SPEED_W-1:0] res_speed_q;
	logic             res_dir_q;
	logic [POS_W-1:0] res_pos_q;

	// Next state
	mode_t            mode_d;
	logic [SPEED_W-1:0] speed_d;
	logic [POS_W-1:0] pos_d;
	logic [POS_W-1:0] tgt_d;
	logic             dir_d;
	logic             notice_d;
	logic [POS_W-1:0] home_pos;
	logic [POS_W-1:0] value_clamped;
	logic [LIMMAX_W-1:0] cfg_max_v;

	logic             advance;
	logic             tick_en;
	dbn_status_t      top_st;
	dbn_status_t      slack_st;

	// Handshake: input register moves on when the result register is free
	assign advance   = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = vld_s1 && out_valid_q && out_stall;
	assign tick_en   = advance && (cmd_s1 == CMD_TICK);
	assign cfg_ready = 1'b1;

	// Configuration writes
	assign cfg_max_v = cfg_data[LIMMAX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_deb_q   <= TOP_DEB_RESET;
			slack_deb_q <= SLACK_DEB_RESET;
			min_pos_q   <= MIN_POS_RESET;
			max_pos_q   <= MAX_POS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TOP_DEB:   top_deb_q   <= cfg_data[DEB_W-1:0];
				CFG_SLACK_DEB: slack_deb_q <= cfg_data[DEB_W-1:0];
				CFG_MIN_POS:   min_pos_q   <= (cfg_data == '0) ? POS_W'(1) : cfg_data;
				CFG_MAX_POS:   max_pos_q   <= (cfg_max_v > POS_LIMIT_MAX) ? POS_LIMIT_MAX
				                                                        : cfg_max_v;
				default: ;
			endcase
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1   <= cmd_t'(cmd);
			top_s1   <= top_sensor;
			slack_s1 <= slack_sensor;
			value_s1 <= value;
		end
	end

	// Sensor debouncers
	wpls_debounce #(.RESET_LEVEL(1'b1)) u_top_dbn (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (tick_en),
		.raw    (top_s1),
		.delay  (top_deb_q),
		.status (top_st)
	);

	wpls_debounce #(.RESET_LEVEL(1'b0)) u_slack_dbn (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (tick_en),
		.raw    (slack_s1),
		.delay  (slack_deb_q),
		.status (slack_st)
	);

	assign home_pos      = clamp_pos(POS_W'(1), min_pos_q, max_pos_q);
	assign value_clamped = clamp_pos(value_s1, min_pos_q, max_pos_q);

	// Next-state logic for one word
	always_comb begin
		mode_d   = mode_q;
		speed_d  = speed_q;
		pos_d    = pos_q;
		tgt_d    = tgt_q;
		dir_d    = dir_q;
		notice_d = 1'b0;
		case (cmd_s1)
			CMD_TICK: begin
				// top sensor: in stops and homes, out returns to travel
				if (top_st.taken) begin
					if (!top_st.level) begin
						speed_d  = '0;
						mode_d   = M_TOP;
						pos_d    = home_pos;
						notice_d = 1'b1;
					end else if (mode_d != dir_mode(dir_d)) begin
						mode_d   = dir_mode(dir_d);
						notice_d = 1'b1;
					end
				end
				// slack sensor: slack stops, release returns to travel
				if (slack_st.taken) begin
					if (!slack_st.level) begin
						if (mode_d != dir_mode(dir_d)) begin
							mode_d   = dir_mode(dir_d);
							notice_d = 1'b1;
						end
					end else begin
						speed_d  = '0;
						mode_d   = M_SLACK;
						notice_d = 1'b1;
					end
				end
				// position limits and target stop
				if (!(mode_d inside {M_TOP, M_SLACK})) begin
					if (pos_d < min_pos_q) begin
						if (mode_d != M_MIN) begin
							speed_d  = '0;
							mode_d   = M_MIN;
							notice_d = 1'b1;
						end
					end else if (pos_d > POS_W'(max_pos_q)) begin
						if (mode_d != M_MAX) begin
							speed_d  = '0;
							mode_d   = M_MAX;
							notice_d = 1'b1;
						end
					end else if ((tgt_d != '0) &&
					             (dir_d ? (pos_d < tgt_d) : (pos_d > tgt_d))) begin
						if (mode_d != M_AT_TARGET) begin
							speed_d  = '0;
							tgt_d    = '0;
							mode_d   = M_AT_TARGET;
							notice_d = 1'b1;
						end
					end else if (mode_d != M_TO_TARGET && mode_d != dir_mode(dir_d)) begin
						mode_d   = dir_mode(dir_d);
						notice_d = 1'b1;
					end
				end
			end
			CMD_ENCODER: begin
				// count down the rope when raising, up when lowering
				if (dir_q) begin
					if (pos_q != '0) begin
						pos_d = pos_q - POS_W'(1);
					end
				end else if (pos_q != POS_MAX) begin
					pos_d = pos_q + POS_W'(1);
				end
			end
			CMD_SET_DIR: begin
				if (value_s1[0] != dir_q) begin
					dir_d = value_s1[0];
					if (mode_q != dir_mode(value_s1[0])) begin
						mode_d   = dir_mode(value_s1[0]);
						notice_d = 1'b1;
					end
				end
			end
			CMD_SET_TGT: begin
				// reverse when the target lies behind the current direction
				if (value_s1 == '0) begin
					tgt_d = '0;
				end else begin
					tgt_d = value_clamped;
					if ((!dir_q && (pos_q > value_clamped)) ||
					    (dir_q && (pos_q < value_clamped))) begin
						dir_d = !dir_q;
						if (mode_q != dir_mode(!dir_q)) begin
							mode_d   = dir_mode(!dir_q);
							notice_d = 1'b1;
						end
					end
				end
			end
			CMD_SET_POS: begin
				pos_d = value_clamped;
			end
			CMD_SET_SPD: begin
				// drop a new nonzero speed while the travel direction is blocked
				if (value_s1 == '0) begin
					speed_d = '0;
				end else if (!(((mode_q inside {M_TOP, M_MIN}) && dir_q) ||
				               ((mode_q inside {M_SLACK, M_MAX}) && !dir_q))) begin
					speed_d = (value_s1 > POS_W'(SPEED_FULL)) ? SPEED_FULL
					                                          : value_s1[SPEED_W-1:0];
				end
			end
			CMD_GO_TGT: begin
				if (value_s1 != '0) begin
					if (tgt_q != '0) begin
						mode_d   = M_TO_TARGET;
						notice_d = 1'b1;
					end
				end else if (mode_q != dir_mode(dir_q)) begin
					mode_d   = dir_mode(dir_q);
					notice_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Supervisor state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_DOWN;
			speed_q <= '0;
			pos_q   <= POS_W'(1);
			tgt_q   <= '0;
			dir_q   <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_d;
			speed_q <= speed_d;
			pos_q   <= pos_d;
			tgt_q   <= tgt_d;
			dir_q   <= dir_d;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_mode_q    <= mode_d;
			res_changed_q <= notice_d;
			res_speed_q   <= speed_d;
			res_dir_q     <= dir_d;
			res_pos_q     <= pos_d;
		end
	end

	// Result outputs
	assign out_valid    = out_valid_q;
	assign mode         = res_mode_q;
	assign mode_changed = res_changed_q;
	assign drive_speed  = res_speed_q;
	assign moving_up    = res_dir_q;
	assign position     = res_pos_q;

endmodule

>>> src/wpls_checker.sv
// Port-level checks for the winch position limit supervisor, bound to the top level.
// Depends on wpls_pkg for mode codes and widths.
module wpls_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [2:0]                     mode,
	input logic                           mode_changed,
	input logic [wpls_pkg::SPEED_W-1:0]   drive_speed,
	input logic                           moving_up,
	input logic [wpls_pkg::POS_W-1:0]     position
);
	import wpls_pkg::*;

	// Entering any stop mode always stops the drive
	a_stop_on_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_changed &&
		(mode == M_TOP || mode == M_SLACK || mode == M_MIN || mode == M_MAX ||
		 mode == M_AT_TARGET)
		|-> drive_speed == '0)
		else $error("stop mode entered with drive running");

	// A travel mode always agrees with the reported direction
	a_travel_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode == M_UP || mode == M_DOWN)
		|-> moving_up == (mode == M_UP))
		else $error("travel mode disagrees with direction");

	// Input back-pressure only while a result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall
		|=> out_valid && $stable(mode) && $stable(mode_changed) &&
		    $stable(drive_speed) && $stable(moving_up) && $stable(position))
		else $error("stalled result word changed");

endmodule

bind winch_position_limit_supervisor wpls_checker u_wpls_checker (.*);

>>> tb/sv/winch_position_limit_supervisor_tb.sv
`timescale 1ns / 1ps
// Testbench for the winch position limit supervisor: directed and random command words,
// each result checked field by field against an in-bench model of the supervisor state.
// Depends on wpls_pkg and the winch_position_limit_supervisor RTL.
module winch_position_limit_supervisor_tb;
	import wpls_pkg::*;

	localparam logic [CMD_W-1:0]     CMD_SPARE = 3'd7;   // not decoded, state unchanged
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'd200; // beyond the register list
	localparam int                   ERR_PRINT_MAX = 40;
	localparam int                   HOLD_CYCLES = 60;

	typedef struct packed {
		logic [2:0]         md;
		logic               changed;
		logic [SPEED_W-1:0] speed;
		logic               up;
		logic [POS_W-1:0]   pos;
	} winch_status_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [CMD_W-1:0]     cmd = CMD_TICK;
	logic                 top_sensor = 1'b1;
	logic                 slack_sensor = 1'b0;
	logic [POS_W-1:0]     value = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [2:0]           mode;
	logic                 mode_changed;
	logic [SPEED_W-1:0]   drive_speed;
	logic                 moving_up;
	logic [POS_W-1:0]     position;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	winch_position_limit_supervisor DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.top_sensor   (top_sensor),
		.slack_sensor (slack_sensor),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mode         (mode),
		.mode_changed (mode_changed),
		.drive_speed  (drive_speed),
		.moving_up    (moving_up),
		.position     (position),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Model of the supervisor state and its configuration
	logic [POS_W-1:0]    cur_pos, tgt_pos, lim_lo;
	logic [LIMMAX_W-1:0] lim_hi;
	logic [SPEED_W-1:0]  spd;
	logic [DEB_W-1:0]    top_cnt, slk_cnt, top_delay, slk_delay;
	logic                heading_up, top_level, top_prev, slk_level, slk_prev, raised;
	mode_t               cur_mode;
	winch_status_t       pending_status[$];
	winch_status_t       want_status;

	// Bench control
	int   n_errors = 0;
	int   n_results = 0;
	bit   calm = 1'b0;       // no gaps and no random stalls while set
	int   hold_reqs = 0;     // requests for a forced result hold-off, raised by the tests
	int   hold_seen = 0;     // requests already taken by the stall process
	int   hold_cnt = 0;
	int   stall_left = 0;
	logic drv_top = 1'b1;    // current raw sensor levels of the random traffic
	logic drv_slack = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle lengths: mostly short, now and then long
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(15, 40);
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 60) begin
			return 0;
		end
		return pick_idle();
	endfunction

	// ---------------------------------------------------------------- model

	function automatic logic [POS_W-1:0] fit_limits(input logic [POS_W-1:0] v);
		if (v < lim_lo) begin
			return lim_lo;
		end else if (v > lim_hi) begin
			return POS_W'(lim_hi);
		end
		return v;
	endfunction

	// Blocked: end stop or limit lies in the current direction
	function automatic logic held_back();
		if (cur_mode == M_TOP || cur_mode == M_MIN) begin
			return heading_up;
		end else if (cur_mode == M_SLACK || cur_mode == M_MAX) begin
			return !heading_up;
		end
		return 1'b0;
	endfunction

	task automatic follow_dir();
		mode_t m;
		if (heading_up) begin
			m = M_UP;
		end else begin
			m = M_DOWN;
		end
		if (cur_mode != m) begin
			raised = 1'b1;
			cur_mode = m;
		end
	endtask

	task automatic stop_in(input mode_t m);
		if (cur_mode != m) begin
			spd = '0;
			raised = 1'b1;
			cur_mode = m;
		end
	endtask

	task automatic turn_to(input logic up);
		if (up != heading_up) begin
			heading_up = up;
			follow_dir();
		end
	endtask

	task automatic debounce_step(input logic raw, input logic [DEB_W-1:0] delay,
			inout logic prev, inout logic [DEB_W-1:0] cnt, inout logic level,
			output logic took);
		took = 1'b0;
		if (raw != prev) begin
			cnt = '0;
		end else if (cnt != TIMER_MAX) begin
			cnt = cnt + 1'b1;
		end
		if (cnt > delay && raw != level) begin
			level = raw;
			took = 1'b1;
		end
		prev = raw;
	endtask

	// Millisecond tick: debounce both sensors, then apply limits and target stop
	task automatic tick_update(input logic tr, input logic sr);
		logic took;
		debounce_step(tr, top_delay, top_prev, top_cnt, top_level, took);
		if (took) begin
			if (!top_level) begin
				spd = '0;
				cur_mode = M_TOP;
				cur_pos = fit_limits(POS_W'(1));
				raised = 1'b1;
			end else begin
				follow_dir();
			end
		end
		debounce_step(sr, slk_delay, slk_prev, slk_cnt, slk_level, took);
		if (took) begin
			if (!slk_level) begin
				follow_dir();
			end else begin
				spd = '0;
				cur_mode = M_SLACK;
				raised = 1'b1;
			end
		end
		if (cur_mode != M_TOP && cur_mode != M_SLACK) begin
			if (cur_pos < lim_lo) begin
				stop_in(M_MIN);
			end else if (cur_pos > lim_hi) begin
				stop_in(M_MAX);
			end else if (tgt_pos != 0 &&
					(heading_up ? (cur_pos < tgt_pos) : (cur_pos > tgt_pos))) begin
				if (cur_mode != M_AT_TARGET) begin
					spd = '0;
					tgt_pos = '0;
					raised = 1'b1;
					cur_mode = M_AT_TARGET;
				end
			end else if (cur_mode != M_TO_TARGET) begin
				follow_dir();
			end
		end
	endtask

	// Advance the model by one accepted word and queue the status it reports
	task automatic predict_word(input logic [CMD_W-1:0] c, input logic tr, input logic sr,
			input logic [POS_W-1:0] v);
		winch_status_t st;
		raised = 1'b0;
		case (c)
			CMD_TICK: begin
				tick_update(tr, sr);
			end
			CMD_ENCODER: begin
				if (heading_up) begin
					if (cur_pos != 0) cur_pos = cur_pos - 1'b1;
				end else if (cur_pos != POS_MAX) begin
					cur_pos = cur_pos + 1'b1;
				end
			end
			CMD_SET_DIR: begin
				turn_to(v[0]);
			end
			CMD_SET_TGT: begin
				if (v == 0) begin
					tgt_pos = '0;
				end else begin
					tgt_pos = fit_limits(v);
					if (!heading_up) begin
						if (cur_pos > tgt_pos) turn_to(1'b1);
					end else if (cur_pos < tgt_pos) begin
						turn_to(1'b0);
					end
				end
			end
			CMD_SET_POS: begin
				cur_pos = fit_limits(v);
			end
			CMD_SET_SPD: begin
				if (v == 0) begin
					spd = '0;
				end else if (!held_back()) begin
					spd = (v > SPEED_FULL) ? SPEED_FULL : v[SPEED_W-1:0];
				end
			end
			CMD_GO_TGT: begin
				if (v != 0) begin
					if (tgt_pos != 0) begin
						cur_mode = M_TO_TARGET;
						raised = 1'b1;
					end
				end else begin
					follow_dir();
				end
			end
			default: begin
			end
		endcase
		st.md = cur_mode;
		st.changed = raised;
		st.speed = spd;
		st.up = heading_up;
		st.pos = cur_pos;
		pending_status.push_back(st);
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		case (idx)
			CFG_TOP_DEB:   top_delay = d[DEB_W-1:0];
			CFG_SLACK_DEB: slk_delay = d[DEB_W-1:0];
			CFG_MIN_POS:   lim_lo = (d == 0) ? POS_W'(1) : d[POS_W-1:0];
			CFG_MAX_POS:   lim_hi = (d[LIMMAX_W-1:0] > POS_LIMIT_MAX) ? POS_LIMIT_MAX
			                                                          : d[LIMMAX_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic reset_model();
		top_delay = TOP_DEB_RESET;
		slk_delay = SLACK_DEB_RESET;
		lim_lo = MIN_POS_RESET;
		lim_hi = MAX_POS_RESET;
		cur_pos = POS_W'(1);
		heading_up = 1'b0;
		cur_mode = M_DOWN;
		tgt_pos = '0;
		spd = '0;
		top_level = 1'b1;
		top_prev = 1'b1;
		top_cnt = '0;
		slk_level = 1'b0;
		slk_prev = 1'b0;
		slk_cnt = '0;
		raised = 1'b0;
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input int got, input int want);
		n_errors++;
		if (n_errors <= ERR_PRINT_MAX) begin
			$display("result %0d: %s is %0d, expected %0d", n_results, what, got, want);
		end
	endtask

	// Check each word taken from the result channel; inputs settle before the falling edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_status.size() == 0) begin
				report_mismatch("unexpected word, mode", mode, 0);
			end else begin
				want_status = pending_status.pop_front();
				if (mode !== want_status.md)
					report_mismatch("mode", mode, want_status.md);
				if (mode_changed !== want_status.changed)
					report_mismatch("mode_changed", mode_changed, want_status.changed);
				if (drive_speed !== want_status.speed)
					report_mismatch("drive_speed", drive_speed, want_status.speed);
				if (moving_up !== want_status.up)
					report_mismatch("moving_up", moving_up, want_status.up);
				if (position !== want_status.pos)
					report_mismatch("position", position, want_status.pos);
			end
		end
	end

	// Hold off results: forced stretches first, then random stalls
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt != 0) begin
			out_stall <= 1'b1;
			hold_cnt--;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!calm && $urandom_range(0, 99) < 30) begin
			out_stall <= 1'b1;
			stall_left = pick_idle() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- driving

	// Offer one word, hold it until taken, then advance the model
	task automatic send_word(input logic [CMD_W-1:0] c, input logic tr, input logic sr,
			input logic [POS_W-1:0] v);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		top_sensor <= tr;
		slack_sensor <= sr;
		value <= v;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		predict_word(c, tr, sr, v);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		apply_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [DEB_W-1:0] t, input logic [DEB_W-1:0] s,
			input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		wait_idle();
		write_reg(CFG_TOP_DEB, CFG_W'(t));
		write_reg(CFG_SLACK_DEB, CFG_W'(s));
		write_reg(CFG_MIN_POS, lo);
		write_reg(CFG_MAX_POS, hi);
	endtask

	// Operand near the current limits, zero, or anywhere in the field
	function automatic logic [POS_W-1:0] pick_operand();
		int r, base;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			return POS_W'($urandom_range(0, 16383));
		end else if (r < 22) begin
			return '0;
		end else if (r < 60) begin
			base = int'(lim_lo);
		end else begin
			base = int'(lim_hi);
		end
		base = base + $urandom_range(0, 20) - 10;
		if (base < 0) base = 0;
		if (base > 16383) base = 16383;
		return POS_W'(base);
	endfunction

	task automatic send_random_word();
		logic [CMD_W-1:0] c;
		logic             tr, sr;
		logic [POS_W-1:0] v;
		int               r;
		r = $urandom_range(0, 99);
		if (r < 35) c = CMD_TICK;
		else if (r < 65) c = CMD_ENCODER;
		else if (r < 72) c = CMD_SET_DIR;
		else if (r < 79) c = CMD_SET_TGT;
		else if (r < 85) c = CMD_SET_POS;
		else if (r < 93) c = CMD_SET_SPD;
		else if (r < 99) c = CMD_GO_TGT;
		else c = CMD_SPARE;
		if (c == CMD_TICK) begin
			// sensors mostly rest out; now and then engage, with one-tick bounces
			if ($urandom_range(0, 99) < (drv_top ? 2 : 12)) drv_top = !drv_top;
			if ($urandom_range(0, 99) < (drv_slack ? 12 : 2)) drv_slack = !drv_slack;
			tr = drv_top;
			sr = drv_slack;
			if ($urandom_range(0, 99) < 2) tr = !tr;
			if ($urandom_range(0, 99) < 2) sr = !sr;
		end else begin
			tr = 1'($urandom_range(0, 1));
			sr = 1'($urandom_range(0, 1));
		end
		case (c)
			CMD_SET_DIR: v = POS_W'($urandom_range(0, 16383));
			CMD_SET_SPD: v = ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(0, 16383))
			                                             : POS_W'($urandom_range(0, 450));
			CMD_GO_TGT:  v = ($urandom_range(0, 3) == 0) ? POS_W'(0)
			                                             : POS_W'($urandom_range(1, 16383));
			default:     v = pick_operand();
		endcase
		send_word(c, tr, sr, v);
	endtask

	// ---------------------------------------------------------------- tests

	// Reset state, clamps, speed gating, direction and target stop at default settings
	task automatic test_commands();
		send_word(CMD_SPARE, 1'b1, 1'b1, 14'h3FFF);
		send_word(CMD_TICK, 1'b1, 1'b0, 14'd0);
		send_word(CMD_SET_POS, 1'b0, 1'b0, 14'd0);
		send_word(CMD_SET_POS, 1'b0, 1'b0, 14'h3FFF);
		send_word(CMD_SET_SPD, 1'b0, 1'b0, 14'h3FFF);
		send_word(CMD_SET_SPD, 1'b0, 1'b0, 14'd0);
		send_word(CMD_ENCODER, 1'b0, 1'b0, 14'd0);
		send_word(CMD_TICK, 1'b1, 1'b0, 14'd0);
		send_word(CMD_SET_SPD, 1'b0, 1'b0, 14'd50);
		send_word(CMD_SET_DIR, 1'b0, 1'b0, 14'h3FFF);
		send_word(CMD_SET_DIR, 1'b0, 1'b0, 14'h3FFE);
		send_word(CMD_SET_DIR, 1'b0, 1'b0, 14'd1);
		send_word(CMD_SET_POS, 1'b0, 1'b0, 14'd101);
		send_word(CMD_SET_TGT, 1'b0, 1'b0, 14'd100);
		send_word(CMD_GO_TGT, 1'b0, 1'b0, 14'd1);
		send_word(CMD_SET_SPD, 1'b0, 1'b0, 14'd300);
		send_word(CMD_ENCODER, 1'b0, 1'b0, 14'd0);
		send_word(CMD_ENCODER, 1'b0, 1'b0, 14'd0);
		send_word(CMD_TICK, 1'b1, 1'b0, 14'd0);
		send_word(CMD_GO_TGT, 1'b0, 1'b0, 14'd5);
		send_word(CMD_GO_TGT, 1'b0, 1'b0, 14'd0);
		send_word(CMD_SET_TGT, 1'b0, 1'b0, 14'd3000);
		send_word(CMD_SET_TGT, 1'b0, 1'b0, 14'd0);
		send_word(CMD_SET_DIR, 1'b0, 1'b0, 14'd1);
		send_word(CMD_SET_POS, 1'b0, 1'b0, 14'd1);
		send_word(CMD_ENCODER, 1'b0, 1'b0, 14'd0);
		send_word(CMD_ENCODER, 1'b0, 1'b0, 14'd0);
		send_word(CMD_TICK, 1'b1, 1'b0, 14'd0);
	endtask

	// Top and slack end stops with short delays, speed refusal and a bouncing sensor
	task automatic test_sensor_debounce();
		int i;
		set_limits(10'd0, 10'd2, 14'd1, 14'd4096);
		send_word(CMD_SET_DIR, 1'b0, 1'b0, 14'd1);
		for (i = 0; i < 2; i++) send_word(CMD_TICK, 1'b0, 1'b0, 14'd0);
		send_word(CMD_SET_SPD, 1'b0, 1'b0, 14'd100);
		send_word(CMD_SET_DIR, 1'b0, 1'b0, 14'd0);
		send_word(CMD_SET_SPD, 1'b0, 1'b0, 14'd100);
		for (i = 0; i < 2; i++) send_word(CMD_TICK, 1'b1, 1'b0, 14'd0);
		for (i = 0; i < 4; i++) send_word(CMD_TICK, 1'b1, 1'b1, 14'd0);
		send_word(CMD_SET_SPD, 1'b0, 1'b0, 14'd80);
		for (i = 0; i < 4; i++) send_word(CMD_TICK, 1'b1, 1'b0, 14'd0);
		for (i = 0; i < 4; i++) send_word(CMD_TICK, i[0], 1'b0, 14'd0);
	endtask

	// Long delay: both sensors held steady until the timers pass it
	task automatic test_long_debounce();
		int i;
		set_limits(10'd1000, 10'd1000, 14'd1, 14'd4096);
		drv_top = 1'b0;
		drv_slack = 1'b1;
		for (i = 0; i < 1003; i++) send_word(CMD_TICK, drv_top, drv_slack, 14'd0);
	endtask

	// Limit register extremes: floor of min, cap of max, min above max, unknown index
	task automatic test_limit_extremes();
		set_limits(10'd3, 10'd3, 14'd0, 14'h3000);
		write_reg(CFG_SPARE, 14'h3FFF);
		send_word(CMD_SET_POS, 1'b0, 1'b0, 14'h3FFF);
		send_word(CMD_TICK, drv_top, drv_slack, 14'd0);
		set_limits(10'd3, 10'd3, 14'h3FFF, 14'd0);
		send_word(CMD_SET_DIR, 1'b0, 1'b0, 14'd0);
		send_word(CMD_SET_POS, 1'b0, 1'b0, 14'd5);
		send_word(CMD_ENCODER, 1'b0, 1'b0, 14'd0);
		send_word(CMD_SET_TGT, 1'b0, 1'b0, 14'd7);
		send_word(CMD_TICK, drv_top, drv_slack, 14'd0);
		send_word(CMD_GO_TGT, 1'b0, 1'b0, 14'd1);
		send_word(CMD_TICK, drv_top, drv_slack, 14'd0);
	endtask

	// Hold results off long enough that the block fills and stalls its input
	task automatic test_backpressure();
		int i;
		set_limits(10'd1, 10'd1, 14'd1, 14'd4096);
		calm = 1'b1;
		hold_reqs++;
		for (i = 0; i < 24; i++) begin
			if (i[0]) begin
				send_word(CMD_TICK, drv_top, drv_slack, 14'd0);
			end else begin
				send_word(CMD_ENCODER, 1'b0, 1'b0, 14'd0);
			end
		end
		calm = 1'b0;
	endtask

	// Random traffic in phases, each with its own delays and limits
	task automatic test_random_traffic();
		int ph, k;
		for (ph = 0; ph < 6; ph++) begin
			if (ph == 5) begin
				set_limits(DEB_W'($urandom_range(0, 3)), DEB_W'($urandom_range(0, 3)),
					14'd1, 14'h1FFF);
			end else begin
				set_limits(DEB_W'($urandom_range(0, 4)), DEB_W'($urandom_range(0, 6)),
					CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(60, 400)));
			end
			calm = (ph == 2);
			for (k = 0; k < 70; k++) send_random_word();
		end
		calm = 1'b0;
	endtask

	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_commands();
		test_sensor_debounce();
		test_long_debounce();
		test_limit_extremes();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (8) @(posedge clk);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
